// File: sv/dll_pkg.sv
// Shared constants, codes and store command types for the linked list unit.
`default_nettype none
package dll_pkg;

	localparam int CAPACITY   = 64;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int LINK_W     = IDX_W + 1;
	localparam int CNT_W      = $clog2(CAPACITY + 1);

	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [LINK_W-1:0]     link_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [DATA_WIDTH-1:0] data_t;

	localparam link_t NIL = LINK_W'(CAPACITY);

	typedef enum logic [4:0] {
		REQ_INS_FIRST  = 5'd0,
		REQ_INS_LAST   = 5'd1,
		REQ_CUR_FIRST  = 5'd2,
		REQ_CUR_LAST   = 5'd3,
		REQ_RD_FIRST   = 5'd4,
		REQ_RD_LAST    = 5'd5,
		REQ_DEL_FIRST  = 5'd6,
		REQ_DEL_LAST   = 5'd7,
		REQ_DEL_AFTER  = 5'd8,
		REQ_DEL_BEFORE = 5'd9,
		REQ_INS_AFTER  = 5'd10,
		REQ_INS_BEFORE = 5'd11,
		REQ_RD_CUR     = 5'd12,
		REQ_WR_CUR     = 5'd13,
		REQ_NEXT       = 5'd14,
		REQ_PREV       = 5'd15,
		REQ_CLEAR      = 5'd16
	} req_e;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_IGNORED = 2'd1,
		ST_RD_ERR  = 2'd2,
		ST_FULL    = 2'd3
	} status_e;

	typedef struct packed {
		idx_t  nx_raddr;
		idx_t  pv_raddr;
		idx_t  val_raddr;
		logic  nx_we;
		idx_t  nx_waddr;
		link_t nx_wdata;
		logic  pv_we;
		idx_t  pv_waddr;
		link_t pv_wdata;
		logic  val_we;
		idx_t  val_waddr;
		data_t val_wdata;
	} store_cmd_t;

	typedef struct packed {
		link_t nx;
		link_t pv;
		data_t val;
	} store_rsp_t;

endpackage
`default_nettype wire

// File: sv/dll_if.sv
// Request and response channel interfaces of the linked list unit.
`default_nettype none
interface dll_req_if;
	logic        valid;
	logic        ready;
	logic [4:0]  req_type;
	logic [31:0] data_value;
	modport source(output valid, req_type, data_value, input ready);
	modport sink(input valid, req_type, data_value, output ready);
endinterface

interface dll_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] read_value;
	logic        cursor_valid;
	logic        list_empty;
	modport source(output valid, status, read_value, cursor_valid, list_empty, input ready);
	modport sink(input valid, status, read_value, cursor_valid, list_empty, output ready);
endinterface
`default_nettype wire

// File: sv/doubly_linked_list_with_cursor_unit.sv
// Doubly linked list over a fixed node pool, with head, tail and cursor.
//
// Requests arrive on the req channel (req_type, data_value); each accepted
// transfer yields exactly one transfer on the rsp channel carrying status,
// read_value, cursor_valid and list_empty as they stand after the request.
// Nodes live in three memories with registered reads; each request reads
// the links it needs, then writes the changed links back in states WR1 and
// WR2, one write per memory per cycle. After acceptance, cursor moves to an
// end, clear and requests rejected at acceptance go straight to FIN, which
// loads the response register; reads, next and prev pass through RD1; inserts
// and deletes through RD1, RD2 where needed, WR1 and WR2 (delete-first skips
// WR2). One request is in progress at a time, and the next one is accepted at
// the earliest in the cycle after the response register is loaded.
// A finished response waits in the output register; the next request is
// accepted meanwhile, and its completion holds until the receiver takes the
// pending response.
// Reset empties the list, frees the pool and leaves the cursor inactive; the
// memories are not cleared, since the allocator never reads an unwritten node.
`default_nettype none
module doubly_linked_list_with_cursor_unit (
	input wire logic clk,
	input wire logic arst_n,
	dll_req_if.sink   req,
	dll_rsp_if.source rsp
);
	import dll_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_RD1  = 6'b000010,
		S_RD2  = 6'b000100,
		S_WR1  = 6'b001000,
		S_WR2  = 6'b010000,
		S_FIN  = 6'b100000
	} state_t;

	state_t     state_q;
	req_e       req_q;
	data_t      dv_q;
	status_e    st_q;
	data_t      rv_q;
	link_t      n_q, m_q;
	link_t      head_q, tail_q, cur_q, free_q;
	cnt_t       fresh_q, count_q;
	logic       out_valid_q;
	status_e    out_st_q;
	data_t      out_rv_q;
	logic       out_cv_q, out_le_q;

	store_cmd_t cmd;
	store_rsp_t mem;

	logic  accept;
	req_e  in_req;
	data_t in_dv;
	logic  full;
	link_t alloc_n;
	logic  out_free;

	dll_store u_store (
		.clk   (clk),
		.cmd   (cmd),
		.rdata (mem)
	);

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign in_req    = req_e'(req.req_type);
	assign in_dv     = req.data_value[DATA_WIDTH-1:0];
	assign full      = (free_q == NIL) && (fresh_q == CNT_W'(CAPACITY));
	assign alloc_n   = (free_q != NIL) ? free_q : LINK_W'(fresh_q);
	assign out_free  = !out_valid_q || rsp.ready;

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_st_q;
	assign rsp.read_value   = 32'(out_rv_q);
	assign rsp.cursor_valid = out_cv_q;
	assign rsp.list_empty   = out_le_q;

	// Memory accesses per sequencer step.
	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				unique case (in_req)
					REQ_INS_FIRST, REQ_INS_LAST, REQ_INS_AFTER, REQ_INS_BEFORE:
						cmd.nx_raddr = free_q[IDX_W-1:0];
					REQ_DEL_FIRST: cmd.nx_raddr = head_q[IDX_W-1:0];
					REQ_DEL_AFTER, REQ_NEXT: cmd.nx_raddr = cur_q[IDX_W-1:0];
					default: cmd.nx_raddr = '0;
				endcase
				unique case (in_req)
					REQ_DEL_LAST: cmd.pv_raddr = tail_q[IDX_W-1:0];
					REQ_DEL_BEFORE, REQ_PREV, REQ_INS_BEFORE:
						cmd.pv_raddr = cur_q[IDX_W-1:0];
					default: cmd.pv_raddr = '0;
				endcase
				unique case (in_req)
					REQ_RD_FIRST: cmd.val_raddr = head_q[IDX_W-1:0];
					REQ_RD_LAST:  cmd.val_raddr = tail_q[IDX_W-1:0];
					default:      cmd.val_raddr = cur_q[IDX_W-1:0];
				endcase
				cmd.val_we    = accept && (in_req == REQ_WR_CUR) && (cur_q != NIL);
				cmd.val_waddr = cur_q[IDX_W-1:0];
				cmd.val_wdata = in_dv;
			end
			S_RD1: begin
				// Second level of the walk: the neighbour of the neighbour, or for insert-after the cursor's forward link.
				cmd.nx_raddr = (req_q == REQ_INS_AFTER) ? cur_q[IDX_W-1:0]
				                                        : mem.nx[IDX_W-1:0];
				cmd.pv_raddr = mem.pv[IDX_W-1:0];
			end
			S_WR1: begin
				cmd.val_waddr = n_q[IDX_W-1:0];
				cmd.val_wdata = dv_q;
				cmd.nx_waddr  = n_q[IDX_W-1:0];
				cmd.pv_waddr  = n_q[IDX_W-1:0];
				unique case (req_q)
					REQ_INS_FIRST: begin
						cmd.val_we = 1'b1;
						cmd.nx_we = 1'b1; cmd.nx_wdata = head_q;
						cmd.pv_we = 1'b1; cmd.pv_wdata = NIL;
					end
					REQ_INS_LAST: begin
						cmd.val_we = 1'b1;
						cmd.nx_we = 1'b1; cmd.nx_wdata = NIL;
						cmd.pv_we = 1'b1; cmd.pv_wdata = tail_q;
					end
					REQ_DEL_FIRST: begin
						cmd.nx_we = 1'b1; cmd.nx_wdata = free_q;
						cmd.pv_we = (head_q != NIL);
						cmd.pv_waddr = head_q[IDX_W-1:0]; cmd.pv_wdata = NIL;
					end
					REQ_DEL_LAST: begin
						cmd.nx_we = 1'b1; cmd.nx_wdata = free_q;
					end
					REQ_DEL_AFTER: begin
						cmd.nx_we = 1'b1;
						cmd.nx_waddr = cur_q[IDX_W-1:0]; cmd.nx_wdata = m_q;
						cmd.pv_we = (m_q != NIL);
						cmd.pv_waddr = m_q[IDX_W-1:0]; cmd.pv_wdata = cur_q;
					end
					REQ_DEL_BEFORE: begin
						cmd.nx_we = 1'b1; cmd.nx_wdata = free_q;
						cmd.pv_we = 1'b1;
						cmd.pv_waddr = cur_q[IDX_W-1:0]; cmd.pv_wdata = m_q;
					end
					REQ_INS_AFTER: begin
						cmd.val_we = 1'b1;
						cmd.nx_we = 1'b1; cmd.nx_wdata = m_q;
						cmd.pv_we = 1'b1; cmd.pv_wdata = cur_q;
					end
					REQ_INS_BEFORE: begin
						cmd.val_we = 1'b1;
						cmd.nx_we = 1'b1; cmd.nx_wdata = cur_q;
						cmd.pv_we = 1'b1; cmd.pv_wdata = m_q;
					end
					default: ;
				endcase
			end
			S_WR2: begin
				unique case (req_q)
					REQ_INS_FIRST: begin
						cmd.pv_we = (head_q != NIL);
						cmd.pv_waddr = head_q[IDX_W-1:0]; cmd.pv_wdata = n_q;
					end
					REQ_INS_LAST: begin
						cmd.nx_we = (tail_q != NIL);
						cmd.nx_waddr = tail_q[IDX_W-1:0]; cmd.nx_wdata = n_q;
					end
					REQ_DEL_LAST: begin
						cmd.nx_we = (tail_q != NIL);
						cmd.nx_waddr = tail_q[IDX_W-1:0]; cmd.nx_wdata = NIL;
					end
					REQ_DEL_AFTER: begin
						cmd.nx_we = 1'b1;
						cmd.nx_waddr = n_q[IDX_W-1:0]; cmd.nx_wdata = free_q;
					end
					REQ_DEL_BEFORE: begin
						cmd.nx_we = (m_q != NIL);
						cmd.nx_waddr = m_q[IDX_W-1:0]; cmd.nx_wdata = cur_q;
					end
					REQ_INS_AFTER: begin
						cmd.nx_we = 1'b1;
						cmd.nx_waddr = cur_q[IDX_W-1:0]; cmd.nx_wdata = n_q;
						cmd.pv_we = (m_q != NIL);
						cmd.pv_waddr = m_q[IDX_W-1:0]; cmd.pv_wdata = n_q;
					end
					REQ_INS_BEFORE: begin
						cmd.pv_we = 1'b1;
						cmd.pv_waddr = cur_q[IDX_W-1:0]; cmd.pv_wdata = n_q;
						cmd.nx_we = (m_q != NIL);
						cmd.nx_waddr = m_q[IDX_W-1:0]; cmd.nx_wdata = n_q;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept) begin
			req_q <= in_req;
			dv_q  <= in_dv;
		end
		if (state_q == S_RD2) begin
			m_q <= (req_q == REQ_DEL_BEFORE) ? mem.pv : mem.nx;
		end else if (state_q == S_RD1 && req_q == REQ_INS_BEFORE) begin
			m_q <= mem.pv;
		end
		if (state_q == S_RD1) begin
			unique case (req_q)
				REQ_INS_FIRST, REQ_INS_LAST, REQ_INS_AFTER, REQ_INS_BEFORE: n_q <= alloc_n;
				REQ_DEL_FIRST: n_q <= head_q;
				REQ_DEL_LAST:  n_q <= tail_q;
				REQ_DEL_BEFORE: n_q <= mem.pv;
				default:       n_q <= mem.nx;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			st_q        <= ST_DONE;
			rv_q        <= '0;
			head_q      <= NIL;
			tail_q      <= NIL;
			cur_q       <= NIL;
			free_q      <= NIL;
			fresh_q     <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			out_st_q    <= ST_DONE;
			out_rv_q    <= '0;
			out_cv_q    <= 1'b0;
			out_le_q    <= 1'b1;
		end else begin
			if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						st_q    <= ST_DONE;
						rv_q    <= '0;
						state_q <= S_FIN;
						unique case (in_req)
							REQ_INS_FIRST, REQ_INS_LAST: begin
								if (full) st_q <= ST_FULL;
								else state_q <= S_RD1;
							end
							REQ_CUR_FIRST: cur_q <= head_q;
							REQ_CUR_LAST:  cur_q <= tail_q;
							REQ_RD_FIRST: begin
								if (head_q == NIL) st_q <= ST_RD_ERR;
								else state_q <= S_RD1;
							end
							REQ_RD_LAST: begin
								if (tail_q == NIL) st_q <= ST_RD_ERR;
								else state_q <= S_RD1;
							end
							REQ_DEL_FIRST: begin
								if (head_q == NIL) st_q <= ST_IGNORED;
								else state_q <= S_RD1;
							end
							REQ_DEL_LAST: begin
								if (tail_q == NIL) st_q <= ST_IGNORED;
								else state_q <= S_RD1;
							end
							REQ_DEL_AFTER, REQ_DEL_BEFORE, REQ_NEXT, REQ_PREV: begin
								if (cur_q == NIL) st_q <= ST_IGNORED;
								else state_q <= S_RD1;
							end
							REQ_INS_AFTER, REQ_INS_BEFORE: begin
								priority if (cur_q == NIL) st_q <= ST_IGNORED;
								else if (full) st_q <= ST_FULL;
								else state_q <= S_RD1;
							end
							REQ_RD_CUR: begin
								if (cur_q == NIL) st_q <= ST_RD_ERR;
								else state_q <= S_RD1;
							end
							REQ_WR_CUR: begin
								if (cur_q == NIL) st_q <= ST_IGNORED;
							end
							REQ_CLEAR: begin
								head_q  <= NIL;
								tail_q  <= NIL;
								cur_q   <= NIL;
								free_q  <= NIL;
								fresh_q <= '0;
								count_q <= '0;
							end
							default: st_q <= ST_IGNORED;
						endcase
					end
				end
				S_RD1: begin
					state_q <= S_FIN;
					unique case (req_q)
						REQ_INS_FIRST, REQ_INS_LAST, REQ_INS_AFTER, REQ_INS_BEFORE: begin
							if (free_q != NIL) free_q <= mem.nx;
							else fresh_q <= fresh_q + 1'b1;
							count_q <= count_q + 1'b1;
							state_q <= (req_q == REQ_INS_AFTER) ? S_RD2 : S_WR1;
						end
						REQ_RD_FIRST, REQ_RD_LAST, REQ_RD_CUR: rv_q <= mem.val;
						REQ_DEL_FIRST: begin
							head_q <= mem.nx;
							if (mem.nx == NIL) tail_q <= NIL;
							state_q <= S_WR1;
						end
						REQ_DEL_LAST: begin
							tail_q <= mem.pv;
							if (mem.pv == NIL) head_q <= NIL;
							state_q <= S_WR1;
						end
						REQ_DEL_AFTER: begin
							if (mem.nx == NIL) st_q <= ST_IGNORED;
							else state_q <= S_RD2;
						end
						REQ_DEL_BEFORE: begin
							if (mem.pv == NIL) st_q <= ST_IGNORED;
							else state_q <= S_RD2;
						end
						REQ_NEXT: cur_q <= (cur_q == tail_q) ? NIL : mem.nx;
						REQ_PREV: cur_q <= (cur_q == head_q) ? NIL : mem.pv;
						default: ;
					endcase
				end
				S_RD2: state_q <= S_WR1;
				S_WR1: begin
					state_q <= (req_q == REQ_DEL_FIRST) ? S_FIN : S_WR2;
					// The freed node joins the free chain in the same cycle as its link write.
					if (req_q == REQ_DEL_FIRST || req_q == REQ_DEL_LAST ||
					    req_q == REQ_DEL_BEFORE) begin
						free_q <= n_q;
						if (count_q != '0) count_q <= count_q - 1'b1;
						if (cur_q == n_q) cur_q <= NIL;
					end
				end
				S_WR2: begin
					state_q <= S_FIN;
					unique case (req_q)
						REQ_INS_FIRST: begin
							head_q <= n_q;
							if (head_q == NIL) tail_q <= n_q;
						end
						REQ_INS_LAST: begin
							tail_q <= n_q;
							if (tail_q == NIL) head_q <= n_q;
						end
						REQ_DEL_AFTER: begin
							if (m_q == NIL) tail_q <= cur_q;
							free_q <= n_q;
							if (count_q != '0) count_q <= count_q - 1'b1;
						end
						REQ_DEL_BEFORE: if (m_q == NIL) head_q <= cur_q;
						REQ_INS_AFTER:  if (m_q == NIL) tail_q <= n_q;
						REQ_INS_BEFORE: if (m_q == NIL) head_q <= n_q;
						default: ;
					endcase
				end
				S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_st_q    <= st_q;
						out_rv_q    <= rv_q;
						out_cv_q    <= (cur_q != NIL);
						out_le_q    <= (count_q == '0);
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: sv/dll_store.sv
// Node store: value, forward link and backward link memories with registered reads.
`default_nettype none
module dll_store (
	input  wire logic                clk,
	input  wire dll_pkg::store_cmd_t cmd,
	output dll_pkg::store_rsp_t      rdata
);
	import dll_pkg::*;

	link_t nx_mem  [CAPACITY];
	link_t pv_mem  [CAPACITY];
	data_t val_mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (cmd.nx_we) begin
			nx_mem[cmd.nx_waddr] <= cmd.nx_wdata;
		end
		if (cmd.pv_we) begin
			pv_mem[cmd.pv_waddr] <= cmd.pv_wdata;
		end
		if (cmd.val_we) begin
			val_mem[cmd.val_waddr] <= cmd.val_wdata;
		end
		rdata.nx  <= nx_mem[cmd.nx_raddr];
		rdata.pv  <= pv_mem[cmd.pv_raddr];
		rdata.val <= val_mem[cmd.val_raddr];
	end
endmodule
`default_nettype wire

// File: sv/dll_checker.sv
// Port-level assertions for the linked list unit, bound to the top level.
`default_nettype none
module dll_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_valid,
	input wire logic        req_ready,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic [1:0]  rsp_status,
	input wire logic [31:0] rsp_read_value,
	input wire logic        rsp_cursor_valid,
	input wire logic        rsp_list_empty
);
	import dll_pkg::*;

	// A response offered and not taken is still offered in the next cycle.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response withdrawn while stalled");

	// One request at a time: an accepted transfer closes the request port.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while another is in progress");

	a_empty_no_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_list_empty |-> !rsp_cursor_valid)
		else $error("cursor active on an empty list");

	a_value_only_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != ST_DONE) |-> (rsp_read_value == 32'd0))
		else $error("read value non-zero on a failed request");
endmodule

bind doubly_linked_list_with_cursor_unit dll_checker u_dll_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_status       (rsp.status),
	.rsp_read_value   (rsp.read_value),
	.rsp_cursor_valid (rsp.cursor_valid),
	.rsp_list_empty   (rsp.list_empty)
);
`default_nettype wire
